@@ rtl/qvr_pkg.sv @@
// Package for the quaternion vector rotation block.
// Holds the field widths, the derived datapath widths and the queue entry type.
// No dependencies; every rtl module imports it.
package qvr_pkg;

  // Larger of two widths, used to keep derived widths sane.
  function automatic int wmax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Field widths and fixed-point scale.
  localparam int VEC_WIDTH  = 16;
  localparam int QUAT_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  // First cross product: product, difference and its double.
  localparam int PROD1_W = VEC_WIDTH + QUAT_WIDTH;
  localparam int C_W     = PROD1_W + 1;
  localparam int C2_W    = C_W + 1;
  // t = round(2c), back at vector scale.
  localparam int T_W     = wmax(C2_W + 1 - FRAC_BITS, 2);

  // Second stage: w*t and qv x t.
  localparam int PROD2_W = QUAT_WIDTH + T_W;
  localparam int S_W     = PROD2_W + 1;
  localparam int U_W     = wmax(PROD2_W + 1 - FRAC_BITS, 2);
  localparam int D_W     = wmax(S_W + 1 - FRAC_BITS, 2);
  // Unsaturated result sum.
  localparam int R_W     = wmax(wmax(U_W, D_W), VEC_WIDTH) + 2;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One queued item: the operands the back part still needs, plus t.
  typedef struct packed {
    logic signed [VEC_WIDTH-1:0]  vx;
    logic signed [VEC_WIDTH-1:0]  vy;
    logic signed [VEC_WIDTH-1:0]  vz;
    logic signed [QUAT_WIDTH-1:0] qx;
    logic signed [QUAT_WIDTH-1:0] qy;
    logic signed [QUAT_WIDTH-1:0] qz;
    logic signed [QUAT_WIDTH-1:0] qw;
    logic signed [T_W-1:0]        tx;
    logic signed [T_W-1:0]        ty;
    logic signed [T_W-1:0]        tz;
  } qvr_item_t;

endpackage

@@ rtl/qvr_front.sv @@
// Front part of the quaternion vector rotation block.
// Captures each accepted item and forms t = round(2 * (qv x v)) in two stages.
// Depends on qvr_pkg.
module qvr_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic signed [qvr_pkg::VEC_WIDTH-1:0]  vec_x,
  input  logic signed [qvr_pkg::VEC_WIDTH-1:0]  vec_y,
  input  logic signed [qvr_pkg::VEC_WIDTH-1:0]  vec_z,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] quat_x,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] quat_y,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] quat_z,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] quat_w,
  output logic                                push,
  output qvr_pkg::qvr_item_t                  item,
  output logic [1:0]                          inflight
);
  import qvr_pkg::*;

  localparam logic [C2_W:0] T_HALF = {{C2_W{1'b0}}, 1'b1} << (FRAC_BITS - 1);

  // Round half up of a value at scale 2^FRAC_BITS back to vector scale.
  function automatic logic signed [T_W-1:0] round_t(input logic signed [C2_W-1:0] x);
    logic signed [C2_W:0] sum;
    logic signed [C2_W:0] shifted;
    sum     = (C2_W + 1)'(x) + $signed(T_HALF);
    shifted = sum >>> FRAC_BITS;
    return shifted[T_W-1:0];
  endfunction

  // Stage A: operands and the six cross-product terms.
  logic                         a_valid;
  logic signed [VEC_WIDTH-1:0]  a_vx, a_vy, a_vz;
  logic signed [QUAT_WIDTH-1:0] a_qx, a_qy, a_qz, a_qw;
  logic signed [PROD1_W-1:0]    a_px_pos, a_px_neg;
  logic signed [PROD1_W-1:0]    a_py_pos, a_py_neg;
  logic signed [PROD1_W-1:0]    a_pz_pos, a_pz_neg;

  // Stage B valid; the payload is the item register itself.
  logic                         b_valid;

  logic signed [C_W-1:0]        cx, cy, cz;

  // Stage A valid follows the transfer at the input.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
    end
  end

  // Stage A payload: the operands and the products of qv x v.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_vx     <= vec_x;
      a_vy     <= vec_y;
      a_vz     <= vec_z;
      a_qx     <= quat_x;
      a_qy     <= quat_y;
      a_qz     <= quat_z;
      a_qw     <= quat_w;
      a_px_pos <= quat_y * vec_z;
      a_px_neg <= quat_z * vec_y;
      a_py_pos <= quat_z * vec_x;
      a_py_neg <= quat_x * vec_z;
      a_pz_pos <= quat_x * vec_y;
      a_pz_neg <= quat_y * vec_x;
    end
  end

  // Cross product differences at full width.
  always_comb begin
    cx = C_W'(a_px_pos) - C_W'(a_px_neg);
    cy = C_W'(a_py_pos) - C_W'(a_py_neg);
    cz = C_W'(a_pz_pos) - C_W'(a_pz_neg);
  end

  // Stage B: double, round and package the item for the queue.
  always_ff @(posedge clk) begin
    if (a_valid) begin
      item.vx <= a_vx;
      item.vy <= a_vy;
      item.vz <= a_vz;
      item.qx <= a_qx;
      item.qy <= a_qy;
      item.qz <= a_qz;
      item.qw <= a_qw;
      item.tx <= round_t({cx, 1'b0});
      item.ty <= round_t({cy, 1'b0});
      item.tz <= round_t({cz, 1'b0});
    end
  end

  assign push     = b_valid;
  assign inflight = {1'b0, a_valid} + {1'b0, b_valid};

endmodule

@@ rtl/qvr_queue.sv @@
// Short queue between the front and back parts of the rotation block.
// Register array with a head read; depth set by QUEUE_DEPTH in qvr_pkg.
// Depends on qvr_pkg.
module qvr_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  qvr_pkg::qvr_item_t          push_item,
  input  logic                        pop,
  output qvr_pkg::qvr_item_t          head,
  output logic                        not_empty,
  output logic [qvr_pkg::QCNT_W-1:0]  count
);
  import qvr_pkg::*;

  qvr_item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr, wr_ptr_next;
  logic [QPTR_W-1:0]     rd_ptr, rd_ptr_next;
  logic [QCNT_W-1:0]     count_next;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);

`ifndef SYNTHESIS
  // A push never lands on a full queue unless an entry leaves in the same cycle.
  assert_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count != QCNT_W'(QUEUE_DEPTH))
    else $error("qvr_queue: push into a full queue");

  // A pop always takes a stored entry.
  assert_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("qvr_queue: pop from an empty queue");
`endif

endmodule

@@ rtl/qvr_back.sv @@
// Back part of the quaternion vector rotation block.
// Forms w*t and qv x t, rounds, adds v, saturates and drives the result strobe.
// Depends on qvr_pkg.
module qvr_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  qvr_pkg::qvr_item_t                  item,
  output logic                                done,
  output logic signed [qvr_pkg::VEC_WIDTH-1:0]  rot_x,
  output logic signed [qvr_pkg::VEC_WIDTH-1:0]  rot_y,
  output logic signed [qvr_pkg::VEC_WIDTH-1:0]  rot_z,
  output logic                                clipped
);
  import qvr_pkg::*;

  localparam logic [PROD2_W:0] U_HALF = {{PROD2_W{1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [S_W:0]     D_HALF = {{S_W{1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [R_W-1:0] R_MAX = R_W'((2 ** (VEC_WIDTH - 1)) - 1);
  localparam logic signed [R_W-1:0] R_MIN = ~R_MAX;

  // Round half up of w*t back to vector scale.
  function automatic logic signed [U_W-1:0] round_u(input logic signed [PROD2_W-1:0] x);
    logic signed [PROD2_W:0] sum;
    logic signed [PROD2_W:0] shifted;
    sum     = (PROD2_W + 1)'(x) + $signed(U_HALF);
    shifted = sum >>> FRAC_BITS;
    return U_W'(shifted);
  endfunction

  // Round half up of a component of qv x t back to vector scale.
  function automatic logic signed [D_W-1:0] round_d(input logic signed [S_W-1:0] x);
    logic signed [S_W:0] sum;
    logic signed [S_W:0] shifted;
    sum     = (S_W + 1)'(x) + $signed(D_HALF);
    shifted = sum >>> FRAC_BITS;
    return D_W'(shifted);
  endfunction

  // Saturate a sum to the vector range; the top bit flags a clip.
  function automatic logic [VEC_WIDTH:0] sat(input logic signed [R_W-1:0] r);
    logic [VEC_WIDTH:0] res;
    if (r > R_MAX) begin
      res = {1'b1, R_MAX[VEC_WIDTH-1:0]};
    end else if (r < R_MIN) begin
      res = {1'b1, R_MIN[VEC_WIDTH-1:0]};
    end else begin
      res = {1'b0, r[VEC_WIDTH-1:0]};
    end
    return res;
  endfunction

  // Stage C: vector carried along, w*t terms and the six qv x t terms.
  logic                         c_valid;
  logic signed [VEC_WIDTH-1:0]  c_vx, c_vy, c_vz;
  logic signed [PROD2_W-1:0]    c_wtx, c_wty, c_wtz;
  logic signed [PROD2_W-1:0]    c_sx_pos, c_sx_neg;
  logic signed [PROD2_W-1:0]    c_sy_pos, c_sy_neg;
  logic signed [PROD2_W-1:0]    c_sz_pos, c_sz_neg;

  logic signed [S_W-1:0]        sx, sy, sz;
  logic signed [R_W-1:0]        rx, ry, rz;
  logic [VEC_WIDTH:0]           satx, saty, satz;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      c_valid <= take;
      done    <= c_valid;
    end
  end

  // Stage C payload: all second-round products.
  always_ff @(posedge clk) begin
    if (take) begin
      c_vx     <= item.vx;
      c_vy     <= item.vy;
      c_vz     <= item.vz;
      c_wtx    <= item.qw * item.tx;
      c_wty    <= item.qw * item.ty;
      c_wtz    <= item.qw * item.tz;
      c_sx_pos <= item.qy * item.tz;
      c_sx_neg <= item.qz * item.ty;
      c_sy_pos <= item.qz * item.tx;
      c_sy_neg <= item.qx * item.tz;
      c_sz_pos <= item.qx * item.ty;
      c_sz_neg <= item.qy * item.tx;
    end
  end

  // Differences, rounding, final sum and saturation.
  always_comb begin
    sx   = S_W'(c_sx_pos) - S_W'(c_sx_neg);
    sy   = S_W'(c_sy_pos) - S_W'(c_sy_neg);
    sz   = S_W'(c_sz_pos) - S_W'(c_sz_neg);
    rx   = R_W'(c_vx) + R_W'(round_u(c_wtx)) + R_W'(round_d(sx));
    ry   = R_W'(c_vy) + R_W'(round_u(c_wty)) + R_W'(round_d(sy));
    rz   = R_W'(c_vz) + R_W'(round_u(c_wtz)) + R_W'(round_d(sz));
    satx = sat(rx);
    saty = sat(ry);
    satz = sat(rz);
  end

  // Stage D: the result registers.
  always_ff @(posedge clk) begin
    if (c_valid) begin
      rot_x   <= satx[VEC_WIDTH-1:0];
      rot_y   <= saty[VEC_WIDTH-1:0];
      rot_z   <= satz[VEC_WIDTH-1:0];
      clipped <= satx[VEC_WIDTH] | saty[VEC_WIDTH] | satz[VEC_WIDTH];
    end
  end

endmodule

@@ rtl/quaternion_vector_rotate.sv @@
// Top level of the quaternion vector rotation block.
// Ties the front part, the queue and the back part together.
// Depends on qvr_pkg, qvr_front, qvr_queue and qvr_back.
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ------------------------------------------
//   input    start high, busy low   vec_x vec_y vec_z quat_x quat_y quat_z quat_w
//   result   done high one cycle    rot_x rot_y rot_z clipped
//
// An item can be transferred in every cycle while busy is low; each result follows
// its transfer through two front stages, one queue slot and two back stages.
// The back part drains the queue every cycle, so busy stays low in normal use.
// busy is high during reset and whenever the queue plus the front stages could
// not hold one more item.
// The receiver cannot stall: done marks each result for exactly one cycle.
module quaternion_vector_rotate (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [qvr_pkg::VEC_WIDTH-1:0]  vec_x,
  input  logic signed [qvr_pkg::VEC_WIDTH-1:0]  vec_y,
  input  logic signed [qvr_pkg::VEC_WIDTH-1:0]  vec_z,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] quat_x,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] quat_y,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] quat_z,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] quat_w,
  output logic                                done,
  output logic signed [qvr_pkg::VEC_WIDTH-1:0]  rot_x,
  output logic signed [qvr_pkg::VEC_WIDTH-1:0]  rot_y,
  output logic signed [qvr_pkg::VEC_WIDTH-1:0]  rot_z,
  output logic                                clipped
);
  import qvr_pkg::*;

  logic               accept;
  logic               push;
  qvr_item_t          front_item;
  logic [1:0]         inflight;
  qvr_item_t          head;
  logic               not_empty;
  logic [QCNT_W-1:0]  count;
  logic [QCNT_W+1:0]  occupancy;

  // Items held or on their way into the queue.
  assign occupancy = (QCNT_W + 2)'(count) + (QCNT_W + 2)'(inflight);
  assign busy      = rst || (occupancy >= (QCNT_W + 2)'(QUEUE_DEPTH));
  assign accept    = start && !busy;

  qvr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .vec_x    (vec_x),
    .vec_y    (vec_y),
    .vec_z    (vec_z),
    .quat_x   (quat_x),
    .quat_y   (quat_y),
    .quat_z   (quat_z),
    .quat_w   (quat_w),
    .push     (push),
    .item     (front_item),
    .inflight (inflight)
  );

  qvr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (not_empty),
    .head      (head),
    .not_empty (not_empty),
    .count     (count)
  );

  qvr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .take    (not_empty),
    .item    (head),
    .done    (done),
    .rot_x   (rot_x),
    .rot_y   (rot_y),
    .rot_z   (rot_z),
    .clipped (clipped)
  );

`ifndef SYNTHESIS
  // Every transfer in yields its result after the front stages, the queue slot and the back stages.
  assert_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 done)
    else $error("quaternion_vector_rotate: result missing after transfer");

  // No result appears without an earlier transfer through the front stages, the queue slot and the back stages.
  assert_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 5))
    else $error("quaternion_vector_rotate: result without a transfer");
`endif

endmodule
